### hw/rtl/assert_macros.svh
// Assertion helpers shared by the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console engine package
// Shared constants, item and result types, and the sequencer state type.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int TCE_COLUMNS = 80;
  localparam int TCE_LINES   = 25;
  localparam int CELL_W      = 16;

  localparam logic [1:0] OP_PUT     = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RECOLOR = 2'd2;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_NUL   = 8'd0;

  localparam logic [2:0] TAB_GLYPHS = 3'd4;

  localparam logic REG_BACKGROUND = 1'b0;
  localparam logic REG_FOREGROUND = 1'b1;

  localparam logic [3:0] BG_RESET = 4'd0;
  localparam logic [3:0] FG_RESET = 4'd7;

  typedef struct packed {
    logic [10:0] cell_index;
    logic [7:0]  character;
    logic [1:0]  op;
  } tce_item_t;

  typedef struct packed {
    logic [4:0]        cursor_line;
    logic [6:0]        cursor_column;
    logic [CELL_W-1:0] cell_value;
  } tce_result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE,
    ST_DISPATCH,
    ST_GLYPH,
    ST_BS,
    ST_SCROLL_COPY,
    ST_SCROLL_FILL,
    ST_RECOLOR,
    ST_RDWAIT,
    ST_DONE
  } tce_state_t;

endpackage
`default_nettype wire

### hw/rtl/tce_screen_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Screen cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tce_screen_mem
  import tce_pkg::*;
#(
  parameter int DEPTH  = TCE_COLUMNS * TCE_LINES,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [CELL_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [CELL_W-1:0] wr_data
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/tce_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Console sequencer
// Cursor registers and the state machine that reads and writes the screen
// memory for items, scroll, recolor and clear passes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tce_seq
  import tce_pkg::*;
#(
  parameter int COLUMNS = TCE_COLUMNS,
  parameter int LINES   = TCE_LINES,
  parameter int CELLS   = COLUMNS * LINES,
  parameter int ADDR_W  = $clog2(CELLS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire tce_item_t         item,
  input  wire logic [7:0]        attr,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output tce_result_t            res,
  output logic                   mem_re,
  output logic      [ADDR_W-1:0] mem_raddr,
  input  wire logic [CELL_W-1:0] mem_rdata,
  output logic                   mem_we,
  output logic      [ADDR_W-1:0] mem_waddr,
  output logic      [CELL_W-1:0] mem_wdata
);

  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CNT_W  = $clog2(CELLS + 1);

  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINES - 1);
  localparam logic [CNT_W-1:0]  S_CELLS   = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0]  S_LAST    = CNT_W'(CELLS - 1);
  localparam logic [CNT_W-1:0]  S_COLS    = CNT_W'(COLUMNS);
  localparam logic [CNT_W-1:0]  S_COLS1   = CNT_W'(COLUMNS + 1);
  localparam logic [CNT_W-1:0]  S_FILL    = CNT_W'(CELLS - COLUMNS);

  tce_state_t        state_r, state_nxt;
  tce_state_t        ret_r, ret_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [CNT_W-1:0]  s_r, s_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  tce_item_t         item_r, item_nxt;
  logic [CELL_W-1:0] value_r, value_nxt;

  logic [ADDR_W-1:0] cur_addr;
  logic [7:0]        glyph;

  assign cur_addr = ADDR_W'(32'(line_r) * COLUMNS + 32'(col_r));
  assign glyph    = (item_r.character == CH_TAB) ? CH_SPACE : item_r.character;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ret_r   <= ST_IDLE;
      col_r   <= '0;
      line_r  <= '0;
      s_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      col_r   <= col_nxt;
      line_r  <= line_nxt;
      s_r     <= s_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    value_r <= value_nxt;
  end

  always_comb begin
    logic       down_req;
    tce_state_t down_ret;
    down_req   = 1'b0;
    down_ret   = ST_DONE;
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    col_nxt    = col_r;
    line_nxt   = line_r;
    s_nxt      = s_r;
    cnt_nxt    = cnt_r;
    item_nxt   = item_r;
    value_nxt  = value_r;
    item_ready = 1'b0;
    res_valid  = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(s_r);
        if (s_r == S_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          item_nxt  = item;
          value_nxt = '0;
          unique case (item.op)
            OP_PUT: begin
              state_nxt = ST_EDGE;
            end
            OP_READ: begin
              if (32'(item.cell_index) < CELLS) begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(item.cell_index);
                state_nxt = ST_RDWAIT;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            OP_RECOLOR: begin
              s_nxt     = '0;
              state_nxt = ST_RECOLOR;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_EDGE: begin
        if (col_r >= COL_LAST) begin
          col_nxt  = '0;
          down_req = 1'b1;
          down_ret = ST_DISPATCH;
        end else begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (item_r.character)
          CH_NL: begin
            col_nxt  = '0;
            down_req = 1'b1;
            down_ret = ST_DONE;
          end
          CH_VT: begin
            down_req = 1'b1;
            down_ret = ST_DONE;
          end
          CH_CR: begin
            col_nxt   = '0;
            state_nxt = ST_DONE;
          end
          CH_TAB: begin
            cnt_nxt   = TAB_GLYPHS;
            state_nxt = ST_GLYPH;
          end
          CH_BS: begin
            if (col_r == '0) begin
              if (line_r != '0) begin
                line_nxt = line_r - 1'b1;
              end
              col_nxt = COL_LAST;
            end else begin
              col_nxt = col_r - 1'b1;
            end
            state_nxt = ST_BS;
          end
          default: begin
            cnt_nxt   = 3'd1;
            state_nxt = ST_GLYPH;
          end
        endcase
      end
      ST_GLYPH: begin
        if (col_r >= COL_LAST) begin
          col_nxt  = '0;
          down_req = 1'b1;
          down_ret = ST_GLYPH;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur_addr;
          mem_wdata = {attr, glyph};
          col_nxt   = col_r + 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
          if (cnt_r == 3'd1) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_BS: begin
        mem_we    = 1'b1;
        mem_waddr = cur_addr;
        mem_wdata = {attr, CH_NUL};
        state_nxt = ST_DONE;
      end
      ST_SCROLL_COPY: begin
        if (s_r < S_CELLS) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(s_r);
        end
        if (s_r > S_COLS) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(s_r - S_COLS1);
          mem_wdata = mem_rdata;
        end
        if (s_r == S_CELLS) begin
          s_nxt     = S_FILL;
          state_nxt = ST_SCROLL_FILL;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      ST_SCROLL_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(s_r);
        mem_wdata = {attr, CH_NUL};
        if (s_r == S_LAST) begin
          state_nxt = ret_r;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      ST_RECOLOR: begin
        if (s_r < S_CELLS) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(s_r);
        end
        if (s_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(s_r - 1'b1);
          mem_wdata = {attr, mem_rdata[7:0]};
        end
        if (s_r == S_CELLS) begin
          state_nxt = ST_DONE;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      ST_RDWAIT: begin
        value_nxt = mem_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (down_req) begin
      if (line_r == LINE_LAST) begin
        s_nxt     = S_COLS;
        ret_nxt   = down_ret;
        state_nxt = ST_SCROLL_COPY;
      end else begin
        line_nxt  = line_r + 1'b1;
        state_nxt = down_ret;
      end
    end
  end

  assign res.cell_value    = value_r;
  assign res.cursor_column = 7'(col_r);
  assign res.cursor_line   = 5'(line_r);

  `TCE_ASSERT_NOW(a_col_range, clk, rst_n, 1'b1, col_r <= COL_LAST, "cursor column out of range")
  `TCE_ASSERT_NOW(a_line_range, clk, rst_n, 1'b1, line_r <= LINE_LAST, "cursor line out of range")
  `TCE_ASSERT_NOW(a_idle_no_write, clk, rst_n, state_r == ST_IDLE, !mem_we, "memory write while idle")
  `TCE_ASSERT_NEXT(a_rdwait_done, clk, rst_n, state_r == ST_RDWAIT, state_r == ST_DONE, "read result lost")

endmodule
`default_nettype wire

### hw/rtl/text_console_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console engine
// A screen of LINES x COLUMNS 16-bit cells (attribute high byte, character
// low byte) with a cursor; puts characters, reads cells, recolors the screen.
// ----------------------------------------------------------------------------
// Every item gives one result beat. All screen traffic goes through a single
// memory with one read and one write port, so one item is worked at a time.
// A move below the last line scrolls the screen, and a recolor walks the
// whole screen. After reset a clearing pass zeroes the screen before the
// first input beat is taken; color writes are taken during it. The next
// input beat is taken while a result still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_engine_unit
  import tce_pkg::*;
#(
  parameter int COLUMNS = TCE_COLUMNS,
  parameter int LINES   = TCE_LINES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Fields from bit 0: op[1:0], character[9:2], cell_index[20:10], zero fill.
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0: cell_value[15:0], cursor_column[22:16],
  // cursor_line[27:23], zero fill.
  output logic      [31:0] out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_data
);

  localparam int CELLS  = COLUMNS * LINES;
  localparam int ADDR_W = $clog2(CELLS);

  logic [3:0]        bg_r;
  logic [3:0]        fg_r;
  logic              out_valid_r;
  tce_result_t       out_res_r;
  tce_item_t         item;
  tce_result_t       res;
  logic              res_valid;
  logic              res_ready;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  assign item.op         = in_tdata[1:0];
  assign item.character  = in_tdata[9:2];
  assign item.cell_index = in_tdata[20:10];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r <= BG_RESET;
      fg_r <= FG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BACKGROUND: bg_r <= cfg_data;
        REG_FOREGROUND: fg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r};

  tce_seq #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES),
    .CELLS   (CELLS),
    .ADDR_W  (ADDR_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .attr       ({bg_r, fg_r}),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata)
  );

  tce_screen_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  `TCE_ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "beat taken while busy")

endmodule
`default_nettype wire
